// ===== rtl/core/bfha_pkg.sv =====
// Shared types and codes for the best-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps
package bfha_pkg;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;

	localparam int unsigned SIZE_W   = 11;
	localparam int unsigned GRAN_W   = 12;
	localparam int unsigned ENTRY_W  = SIZE_W + 1;
	localparam logic [16:0] ROUND_ADD = 17'h00022;
	localparam logic [14:0] HDR_BYTES = 15'd3;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [14:0] data_address;
	} result_t;

endpackage

// ===== rtl/core/best_fit_heap_allocator_top.sv =====
// Top level of the best-fit heap allocator: stream ports, output register,
// block store. Depends on bfha_pkg, bfha_ram, bfha_walker.
//
//  channel  | direction | tdata / tuser
//  s_axis   | in        | tuser: req_type; tdata: request_bytes, block_address
//  m_axis   | out       | tdata: status, data_address
//
// An allocate walks the chain of blocks until an exact fit or the chain's end;
// a free walks up to its target, or the whole chain for a stale address. The
// walk is set by the single read port of the store.
// After reset the walker writes the whole-heap block before input is taken.
// A result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module best_fit_heap_allocator_top #(
	parameter int HEAP_GRANULES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] request_bytes, [30:16] block_address
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [1:0] status, [16:2] data_address
);
	import bfha_pkg::*;

	localparam int AW = $clog2(HEAP_GRANULES);

	result_t              res;
	logic                 take;
	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [ENTRY_W-1:0]   wdata, rdata;
	logic [1:0]           status_q;
	logic [14:0]          addr_q;

	assign take = res.valid && (!m_axis_tvalid || m_axis_tready);

	bfha_walker #(.HEAP_GRANULES(HEAP_GRANULES)) u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (s_axis_tvalid && s_axis_tready),
		.req_type      (s_axis_tuser),
		.request_bytes (s_axis_tdata[15:0]),
		.block_address (s_axis_tdata[30:16]),
		.ready         (s_axis_tready),
		.result        (res),
		.result_take   (take),
		.mem_we        (we),
		.mem_waddr     (waddr),
		.mem_wdata     (wdata),
		.mem_raddr     (raddr),
		.mem_rdata     (rdata)
	);

	bfha_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_GRANULES)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (take) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= res.status;
			addr_q   <= res.data_address;
		end
	end

	assign m_axis_tdata = {7'd0, addr_q, status_q};

endmodule

// ===== rtl/core/bfha_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bfha_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/bfha_walker.sv =====
// Block-chain walker: sequences reads and write-backs of the block store.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
module bfha_walker #(
	parameter int HEAP_GRANULES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             req_type,
	input  logic [15:0]                      request_bytes,
	input  logic [14:0]                      block_address,
	output logic                             ready,
	output bfha_pkg::result_t                result,
	input  logic                             result_take,
	output logic                             mem_we,
	output logic [$clog2(HEAP_GRANULES)-1:0] mem_waddr,
	output logic [bfha_pkg::ENTRY_W-1:0]     mem_wdata,
	output logic [$clog2(HEAP_GRANULES)-1:0] mem_raddr,
	input  logic [bfha_pkg::ENTRY_W-1:0]     mem_rdata
);
	import bfha_pkg::*;

	localparam int AW = $clog2(HEAP_GRANULES);
	localparam logic [GRAN_W-1:0] HEAP_C = GRAN_W'(HEAP_GRANULES);

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_EVAL  = 9'b000000100,
		S_NEXT  = 9'b000001000,
		S_FWR   = 9'b000010000,
		S_FPREV = 9'b000100000,
		S_WB1   = 9'b001000000,
		S_WB2   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic               type_q;
	logic [GRAN_W-1:0]  need_q, g_q, best_q, bsz_q, cur_q, prev_q, psz_q;
	logic [9:0]         target_q;
	logic               hb_q, hp_q, pfree_q;
	logic [1:0]         status_q;
	logic [14:0]        addr_q;

	logic [16:0]        need_sum;
	logic [14:0]        a_m3;
	logic               addr_bad;
	logic [GRAN_W-1:0]  sz, gn, rest, nsum;
	logic               fr, take_now;

	assign need_sum = {1'b0, request_bytes} + ROUND_ADD;
	assign a_m3     = block_address - HDR_BYTES;
	assign addr_bad = (block_address < HDR_BYTES) || (a_m3[4:0] != 5'd0);

	assign sz       = {1'b0, mem_rdata[SIZE_W-1:0]};
	assign fr       = mem_rdata[SIZE_W];
	assign gn       = g_q + sz;
	assign rest     = best_q + need_q;
	assign nsum     = cur_q + sz;
	assign take_now = fr && (sz > need_q) && (!hb_q || sz < bsz_q);

	assign ready = (state_q == S_IDLE);
	assign result.valid        = (state_q == S_DONE);
	assign result.status       = status_q;
	assign result.data_address = addr_q;

	// Read port: restart at granule zero, else follow the chain.
	always_comb begin
		case (state_q)
			S_IDLE:  mem_raddr = '0;
			S_EVAL:  mem_raddr = gn[AW-1:0];
			default: mem_raddr = g_q[AW-1:0];
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = g_q[AW-1:0];
		mem_wdata = '0;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b1, HEAP_C[SIZE_W-1:0]};
			end
			S_EVAL: begin
				if (type_q == REQ_ALLOC && sz != '0 && fr && sz == need_q) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b0, sz[SIZE_W-1:0]};
				end
			end
			S_FWR: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, cur_q[SIZE_W-1:0]};
			end
			S_FPREV: begin
				mem_we    = 1'b1;
				mem_waddr = prev_q[AW-1:0];
				mem_wdata = {1'b1, psz_q[SIZE_W-1:0] + cur_q[SIZE_W-1:0]};
			end
			S_WB1: begin
				mem_we    = 1'b1;
				mem_waddr = best_q[AW-1:0];
				mem_wdata = {1'b0, need_q[SIZE_W-1:0]};
			end
			S_WB2: begin
				mem_we    = 1'b1;
				mem_waddr = rest[AW-1:0];
				mem_wdata = {1'b1, bsz_q[SIZE_W-1:0] - need_q[SIZE_W-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			hb_q    <= 1'b0;
			hp_q    <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						type_q   <= req_type;
						need_q   <= need_sum[16:5];
						target_q <= a_m3[14:5];
						g_q      <= '0;
						hb_q     <= 1'b0;
						hp_q     <= 1'b0;
						addr_q   <= '0;
						if (req_type == REQ_FREE && addr_bad) begin
							status_q <= ST_BAD_ADDR;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (type_q == REQ_ALLOC) begin
						if (sz == '0) begin
							status_q <= ST_NO_SPACE;
							state_q  <= hb_q ? S_WB1 : S_DONE;
						end else if (fr && sz == need_q) begin
							status_q <= ST_OK;
							addr_q   <= {g_q[9:0], 5'd3};
							state_q  <= S_DONE;
						end else begin
							if (take_now) begin
								best_q <= g_q;
								bsz_q  <= sz;
								hb_q   <= 1'b1;
							end
							g_q <= gn;
							if (gn >= HEAP_C) begin
								status_q <= ST_NO_SPACE;
								state_q  <= (hb_q || take_now) ? S_WB1 : S_DONE;
							end
						end
					end else begin
						if (sz == '0) begin
							status_q <= ST_BAD_ADDR;
							state_q  <= S_DONE;
						end else if (g_q == {2'b00, target_q}) begin
							cur_q <= sz;
							if (fr) begin
								status_q <= ST_BAD_ADDR;
								state_q  <= S_DONE;
							end else if (gn < HEAP_C) begin
								// Hold g on the target; the read goes to the next block.
								state_q <= S_NEXT;
							end else begin
								state_q <= S_FWR;
							end
						end else begin
							prev_q  <= g_q;
							psz_q   <= sz;
							pfree_q <= fr;
							hp_q    <= 1'b1;
							g_q     <= gn;
							if (gn >= HEAP_C) begin
								status_q <= ST_BAD_ADDR;
								state_q  <= S_DONE;
							end
						end
					end
				end
				S_NEXT: begin
					if (fr) begin
						cur_q <= nsum;
					end
					state_q <= S_FWR;
				end
				S_FWR: begin
					status_q <= ST_OK;
					state_q  <= (hp_q && pfree_q) ? S_FPREV : S_DONE;
				end
				S_FPREV: state_q <= S_DONE;
				S_WB1: begin
					status_q <= ST_OK;
					addr_q   <= {best_q[9:0], 5'd3};
					state_q  <= (rest < HEAP_C) ? S_WB2 : S_DONE;
				end
				S_WB2: state_q <= S_DONE;
				S_DONE: begin
					if (result_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("walker state not one-hot");
	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE && state_q != S_DONE && state_q != S_NEXT))
		else $error("store written outside a write step");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (status_q == ST_OK || status_q == ST_NO_SPACE
			|| status_q == ST_BAD_ADDR))
		else $error("undefined status code");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && status_q != ST_OK) |-> (addr_q == '0))
		else $error("address on a failed request");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for best_fit_heap_allocator_top: a table of directed
// requests, then random allocate/free traffic, checked against a local model.
// Depends on bfha_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb;
	import bfha_pkg::*;

	localparam int GRANULES = 1024;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 560;

	typedef struct {
		logic [1:0]  status;
		logic [14:0] data_address;
	} alloc_result_t;

	typedef struct {
		logic        kind;
		logic [15:0] nbytes;
		logic [14:0] addr;
		bit          typed;
		logic [1:0]  status;
		logic [14:0] data_address;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [15:0] request_bytes, [30:16] block_address
	logic        s_axis_tuser;  // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // [1:0] status, [16:2] data_address

	best_fit_heap_allocator_top #(.HEAP_GRANULES(GRANULES)) dut (.*);

	logic [10:0]   blk_size [GRANULES];
	bit            blk_free [GRANULES];
	logic [14:0]   live_addrs[$];
	logic [14:0]   freed_addrs[$];
	alloc_result_t pending_results[$];
	int            fail_count;
	int            idle_cycles;
	int            burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Model of the heap: best-fit allocate with split, free with coalescing.
	function automatic alloc_result_t heap_step(logic kind, logic [15:0] nbytes,
			logic [14:0] addr);
		alloc_result_t r;
		int need, g, best, best_sz, sz, tgt, prev, nxt;
		bit have_best, have_prev;
		r.status = ST_OK;
		r.data_address = '0;
		if (kind == REQ_ALLOC) begin
			need = (int'(nbytes) + 34) >> 5;
			g = 0;
			have_best = 0;
			best = 0;
			best_sz = 0;
			while (g < GRANULES) begin
				sz = blk_size[g];
				if (sz == 0) break;
				if (blk_free[g]) begin
					if (sz == need) begin
						blk_free[g] = 0;
						r.data_address = 15'(g * 32 + 3);
						return r;
					end
					if (sz > need && (!have_best || sz < best_sz)) begin
						best = g;
						best_sz = sz;
						have_best = 1;
					end
				end
				g += sz;
			end
			if (!have_best) begin
				r.status = ST_NO_SPACE;
				return r;
			end
			if (best + need < GRANULES) begin
				blk_size[best + need] = 11'(best_sz - need);
				blk_free[best + need] = 1;
			end
			blk_size[best] = 11'(need);
			blk_free[best] = 0;
			r.data_address = 15'(best * 32 + 3);
			return r;
		end
		r.status = ST_BAD_ADDR;
		if (addr < 3 || ((addr - 3) & 15'h1f) != 0) return r;
		tgt = (int'(addr) - 3) >> 5;
		g = 0;
		prev = 0;
		have_prev = 0;
		while (g < GRANULES) begin
			sz = blk_size[g];
			if (sz == 0) break;
			if (g == tgt) begin
				if (blk_free[g]) return r;
				blk_free[g] = 1;
				nxt = g + sz;
				if (nxt < GRANULES && blk_free[nxt]) begin
					sz += blk_size[nxt];
					blk_size[g] = 11'(sz);
				end
				if (have_prev && blk_free[prev]) blk_size[prev] = 11'(blk_size[prev] + sz);
				r.status = ST_OK;
				return r;
			end
			prev = g;
			have_prev = 1;
			g += sz;
		end
		return r;
	endfunction

	// Called at a rising edge; returns after the take and any random idle gap.
	task automatic send_request(request_row_t row);
		alloc_result_t r;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= row.kind;
		s_axis_tdata <= {1'b0, row.addr, row.nbytes};
		do @(posedge clk); while (!s_axis_tready);
		r = heap_step(row.kind, row.nbytes, row.addr);
		if (row.kind == REQ_ALLOC && r.status == ST_OK) live_addrs.push_back(r.data_address);
		if (row.kind == REQ_FREE && r.status == ST_OK) begin
			foreach (live_addrs[i]) if (live_addrs[i] == row.addr) begin
				live_addrs.delete(i);
				break;
			end
			freed_addrs.push_back(row.addr);
			if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
		end
		if (row.typed) begin
			r.status = row.status;
			r.data_address = row.data_address;
		end
		pending_results.push_back(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Receiver stall pattern: mode set by bits [9:8] of a free-running cycle counter.
	int rx_cycle;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			case (rx_cycle[9:8])
				2'd0: m_axis_tready <= 1'b1;
				2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= rx_cycle[2];
			endcase
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d data_address %0d",
					m_axis_tdata[1:0], m_axis_tdata[16:2]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[1:0] !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, m_axis_tdata[1:0]);
					fail_count++;
				end
				if (m_axis_tdata[16:2] !== want.data_address) begin
					$error("data_address: expected %0d actual %0d",
						want.data_address, m_axis_tdata[16:2]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	request_row_t directed [] = '{
		'{REQ_ALLOC, 16'd0,     15'd0,     1, ST_OK,       15'd3},
		'{REQ_ALLOC, 16'hffff,  15'd0,     1, ST_NO_SPACE, 15'd0},
		'{REQ_FREE,  16'd0,     15'd0,     1, ST_BAD_ADDR, 15'd0},
		'{REQ_FREE,  16'd0,     15'd4,     1, ST_BAD_ADDR, 15'd0},
		'{REQ_FREE,  16'hffff,  15'd3,     1, ST_OK,       15'd0},
		'{REQ_FREE,  16'd0,     15'd3,     1, ST_BAD_ADDR, 15'd0},
		'{REQ_FREE,  16'd0,     15'h7fff,  1, ST_BAD_ADDR, 15'd0},
		'{REQ_ALLOC, 16'd32765, 15'h7fff,  1, ST_OK,       15'd3},
		'{REQ_ALLOC, 16'd0,     15'd0,     1, ST_NO_SPACE, 15'd0},
		'{REQ_FREE,  16'd0,     15'd3,     1, ST_OK,       15'd0},
		'{REQ_ALLOC, 16'd32766, 15'd0,     1, ST_NO_SPACE, 15'd0},
		'{REQ_ALLOC, 16'd29,    15'd0,     0, ST_OK,       15'd0},
		'{REQ_ALLOC, 16'd30,    15'd0,     0, ST_OK,       15'd0},
		'{REQ_ALLOC, 16'd100,   15'd0,     0, ST_OK,       15'd0},
		'{REQ_ALLOC, 16'd60,    15'd0,     0, ST_OK,       15'd0},
		'{REQ_FREE,  16'd0,     15'd35,    0, ST_OK,       15'd0},
		'{REQ_FREE,  16'd0,     15'd99,    0, ST_OK,       15'd0},
		'{REQ_FREE,  16'd0,     15'd67,    0, ST_OK,       15'd0},
		'{REQ_ALLOC, 16'd40,    15'd0,     0, ST_OK,       15'd0},
		'{REQ_FREE,  16'd0,     15'd32675, 0, ST_OK,       15'd0},
		'{REQ_FREE,  16'd0,     15'd32739, 0, ST_OK,       15'd0}
	};

	initial begin
		request_row_t row;
		int pick;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_ALLOC;
		fail_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		foreach (blk_size[i]) begin
			blk_size[i] = '0;
			blk_free[i] = 0;
		end
		blk_size[0] = 11'(GRANULES);
		blk_free[0] = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_request(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until the allocator has drained
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			row.typed = 0;
			row.status = ST_OK;
			row.data_address = '0;
			row.nbytes = 16'($urandom);
			row.addr = 15'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				row.kind = 1'($urandom);
			end else if (live_addrs.size() > 0 &&
					pick < (live_addrs.size() > 40 ? 70 : 45)) begin
				row.kind = REQ_FREE;
				row.addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
			end else if (pick < 55 && freed_addrs.size() > 0) begin
				row.kind = REQ_FREE;
				row.addr = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
			end else if (pick < 60) begin
				row.kind = REQ_FREE;
				row.addr = 15'($urandom_range(0, 1023) * 32 + 3);
			end else begin
				row.kind = REQ_ALLOC;
				row.nbytes = (pick < 66) ? 16'($urandom_range(0, 4000))
					: 16'($urandom_range(0, 300));
			end
			send_request(row);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
